// ===== rtl/wpsa_pkg.sv =====
// shared types and constants of the weighted pixel sample accumulator
package wpsa_pkg;

    localparam int ADDR_W = 21;
    localparam int DEPTH = 2 ** ADDR_W;
    localparam int SUM_W = 40;
    localparam int WSUM_W = 32;
    localparam int CHAN_W = 24;
    localparam int FRAC_SHIFT = 12;

    localparam logic [11:0] MAX_WIDTH = 12'd2048;
    localparam logic [10:0] MAX_HEIGHT = 11'd1024;
    localparam logic [11:0] WIDTH_RESET = 12'd1280;
    localparam logic [10:0] HEIGHT_RESET = 11'd720;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_READ = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_WIDTH = 2'd0,
        REG_HEIGHT = 2'd1
    } reg_index_t;

    typedef struct packed {
        op_t op;
        logic oor;
        logic [ADDR_W-1:0] addr;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [15:0] weight;
    } cmd_t;

    typedef struct packed {
        logic [SUM_W-1:0] red_sum;
        logic [SUM_W-1:0] green_sum;
        logic [SUM_W-1:0] blue_sum;
        logic [WSUM_W-1:0] weight_sum;
    } pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic no_weight;
        logic out_of_range;
    } result_t;

endpackage

// ===== rtl/weighted_pixel_sample_accumulator_top.sv =====
// top level of the weighted pixel sample accumulator
// add: the back end pops and reads the store, then writes the sum back; next add overlaps intake
// read: store read, then weight and saturation check, the divider, then the push into the result queue
// clear: sweeps all 2^21 store words, one store word per cycle, no word accepted meanwhile
// reset: asynchronous, active low; a clearing sweep of all 2^21 store words follows reset
// width and height return to 1280 and 720
module weighted_pixel_sample_accumulator_top
    import wpsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        op,
    input  logic [11:0]       column,
    input  logic [11:0]       row,
    input  logic [CHAN_W-1:0] sample_red,
    input  logic [CHAN_W-1:0] sample_green,
    input  logic [CHAN_W-1:0] sample_blue,
    input  logic [15:0]       sample_weight,
    input  logic              pop,
    output logic              empty,
    output logic [CHAN_W-1:0] pixel_red,
    output logic [CHAN_W-1:0] pixel_green,
    output logic [CHAN_W-1:0] pixel_blue,
    output logic              no_weight,
    output logic              out_of_range
);

    logic q_push, q_full, q_empty, q_pop, clearing;
    cmd_t q_in, q_out;
    result_t result;

    assign full = q_full || clearing;

    wpsa_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .accept(push && !full),
        .op(op),
        .column(column),
        .row(row),
        .sample_red(sample_red),
        .sample_green(sample_green),
        .sample_blue(sample_blue),
        .sample_weight(sample_weight),
        .q_push(q_push),
        .q_data(q_in)
    );

    wpsa_cmd_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(q_in),
        .full(q_full),
        .pop(q_pop),
        .pop_data(q_out),
        .empty(q_empty)
    );

    wpsa_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .q_data(q_out),
        .q_empty(q_empty),
        .q_pop(q_pop),
        .clearing(clearing),
        .pop(pop),
        .empty(empty),
        .result(result)
    );

    assign pixel_red = result.red;
    assign pixel_green = result.green;
    assign pixel_blue = result.blue;
    assign no_weight = result.no_weight;
    assign out_of_range = result.out_of_range;

endmodule

// ===== rtl/wpsa_ram.sv =====
// generic single write port ram with registered read
module wpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/wpsa_cmd_queue.sv =====
// two entry command queue between front and back
module wpsa_cmd_queue
    import wpsa_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t entry_reg [2];
    logic wr_ptr_reg, wr_ptr_next;
    logic rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/wpsa_front.sv =====
// front end: configuration registers, range check, address and classification
module wpsa_front
    import wpsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [11:0]       cfg_data,
    input  logic              accept,
    input  logic [1:0]        op,
    input  logic [11:0]       column,
    input  logic [11:0]       row,
    input  logic [CHAN_W-1:0] sample_red,
    input  logic [CHAN_W-1:0] sample_green,
    input  logic [CHAN_W-1:0] sample_blue,
    input  logic [15:0]       sample_weight,
    output logic              q_push,
    output cmd_t              q_data
);

    logic [11:0] width_reg, width_next;
    logic [10:0] height_reg, height_next;
    logic [11:0] w_eff;
    logic [10:0] h_eff;
    logic in_image;
    logic [21:0] prod;
    op_t op_code;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_WIDTH: width_next = cfg_data;
                REG_HEIGHT: height_next = cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
        end
    end

    always_comb
    begin
        priority if (width_reg == 12'd0)
            w_eff = 12'd1;
        else if (width_reg > MAX_WIDTH)
            w_eff = MAX_WIDTH;
        else
            w_eff = width_reg;
        priority if (height_reg == 11'd0)
            h_eff = 11'd1;
        else if (height_reg > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = height_reg;
    end

    assign in_image = (column < w_eff) && (row < {1'b0, h_eff});
    assign prod = w_eff * row[9:0];
    assign op_code = op_t'(op);

    always_comb
    begin
        q_data.op = op_code;
        q_data.oor = !in_image;
        q_data.addr = prod[ADDR_W-1:0] + {10'd0, column[10:0]};
        q_data.red = sample_red;
        q_data.green = sample_green;
        q_data.blue = sample_blue;
        q_data.weight = sample_weight;
        unique case (op_code)
            OP_ADD: q_push = accept && in_image;
            OP_READ: q_push = accept;
            OP_CLEAR: q_push = accept;
            OP_NONE: q_push = 1'b0;
        endcase
    end

endmodule

// ===== rtl/wpsa_div.sv =====
// three lane restoring divider, one quotient bit per cycle
module wpsa_div
    import wpsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  red_sum,
    input  logic [SUM_W-1:0]  green_sum,
    input  logic [SUM_W-1:0]  blue_sum,
    input  logic [WSUM_W-1:0] weight_sum,
    output logic              last,
    output logic [CHAN_W-1:0] red_q,
    output logic [CHAN_W-1:0] green_q,
    output logic [CHAN_W-1:0] blue_q
);

    logic [4:0] count_reg, count_next;
    logic [WSUM_W-1:0] divisor_reg;
    logic [WSUM_W-1:0] rem_reg [3];
    logic [WSUM_W-1:0] rem_next [3];
    logic [CHAN_W-1:0] low_reg [3];
    logic [CHAN_W-1:0] low_next [3];
    logic [CHAN_W-1:0] q_reg [3];
    logic [CHAN_W-1:0] q_next [3];
    logic [SUM_W-1:0] sums [3];
    logic [WSUM_W:0] trial [3];
    logic ge [3];

    assign sums[0] = red_sum;
    assign sums[1] = green_sum;
    assign sums[2] = blue_sum;
    assign last = (count_reg == 5'd1);

    always_comb
    begin
        count_next = count_reg;
        if (start)
            count_next = 5'(CHAN_W);
        else if (count_reg != 5'd0)
            count_next = count_reg - 5'd1;
        for (int i = 0; i < 3; i++)
        begin
            trial[i] = {rem_reg[i], low_reg[i][CHAN_W-1]};
            ge[i] = trial[i] >= {1'b0, divisor_reg};
            rem_next[i] = rem_reg[i];
            low_next[i] = low_reg[i];
            q_next[i] = q_reg[i];
            if (start)
            begin
                rem_next[i] = {4'd0, sums[i][SUM_W-1:FRAC_SHIFT]};
                low_next[i] = {sums[i][FRAC_SHIFT-1:0], 12'd0};
                q_next[i] = '0;
            end
            else if (count_reg != 5'd0)
            begin
                rem_next[i] = ge[i] ? WSUM_W'(trial[i] - {1'b0, divisor_reg})
                                    : trial[i][WSUM_W-1:0];
                low_next[i] = {low_reg[i][CHAN_W-2:0], 1'b0};
                q_next[i] = {q_reg[i][CHAN_W-2:0], ge[i]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 5'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= weight_sum;
        end
        for (int i = 0; i < 3; i++)
        begin
            rem_reg[i] <= rem_next[i];
            low_reg[i] <= low_next[i];
            q_reg[i] <= q_next[i];
        end
    end

    assign red_q = q_reg[0];
    assign green_q = q_reg[1];
    assign blue_q = q_reg[2];

endmodule

// ===== rtl/wpsa_back.sv =====
// back end: store read-modify-write, clearing sweep, resolve and result queue
module wpsa_back
    import wpsa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  q_data,
    input  logic  q_empty,
    output logic  q_pop,
    output logic  clearing,
    input  logic  pop,
    output logic  empty,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_READ,
        ST_DIV,
        ST_PUSH
    } state_t;

    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic [ADDR_W-1:0] clear_pos_reg, clear_pos_next;
    logic nw_reg, nw_next;
    logic [2:0] sat_reg, sat_next;

    logic wr_en;
    logic [ADDR_W-1:0] wr_addr;
    pix_t wr_data, rd_data;
    logic rd_en;
    logic [SUM_W:0] red_add, green_add, blue_add;
    logic [WSUM_W:0] weight_add;
    logic [SUM_W+FRAC_SHIFT-1:0] ws_scaled;
    logic div_start, div_last;
    logic [CHAN_W-1:0] red_q, green_q, blue_q;
    result_t res;
    logic res_push;

    result_t out_reg [2];
    logic out_wr_reg, out_rd_reg;
    logic [1:0] out_count_reg;
    logic out_full, out_pop;

    wpsa_ram #(
        .WIDTH($bits(pix_t)),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en(rd_en),
        .rd_addr(q_data.addr),
        .rd_data(rd_data)
    );

    wpsa_div u_div (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .red_sum(rd_data.red_sum),
        .green_sum(rd_data.green_sum),
        .blue_sum(rd_data.blue_sum),
        .weight_sum(rd_data.weight_sum),
        .last(div_last),
        .red_q(red_q),
        .green_q(green_q),
        .blue_q(blue_q)
    );

    assign red_add = {1'b0, rd_data.red_sum} + (SUM_W+1)'(cmd_reg.red);
    assign green_add = {1'b0, rd_data.green_sum} + (SUM_W+1)'(cmd_reg.green);
    assign blue_add = {1'b0, rd_data.blue_sum} + (SUM_W+1)'(cmd_reg.blue);
    assign weight_add = {1'b0, rd_data.weight_sum} + (WSUM_W+1)'(cmd_reg.weight);
    assign ws_scaled = {rd_data.weight_sum, 20'd0} >> 8;

    assign clearing = (state_reg == ST_CLEAR);
    assign out_full = (out_count_reg == 2'd2);

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        clear_pos_next = clear_pos_reg;
        nw_next = nw_reg;
        sat_next = sat_reg;
        q_pop = 1'b0;
        rd_en = 1'b0;
        wr_en = 1'b0;
        wr_addr = cmd_reg.addr;
        wr_data = '0;
        div_start = 1'b0;
        res_push = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                wr_addr = clear_pos_reg;
                clear_pos_next = clear_pos_reg + 1'b1;
                if (&clear_pos_reg)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    cmd_next = q_data;
                    nw_next = 1'b0;
                    sat_next = 3'd0;
                    unique case (q_data.op)
                        OP_ADD:
                        begin
                            rd_en = 1'b1;
                            state_next = ST_ADD;
                        end
                        OP_READ:
                        begin
                            rd_en = !q_data.oor;
                            state_next = q_data.oor ? ST_PUSH : ST_READ;
                        end
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_NONE: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:
            begin
                wr_en = 1'b1;
                wr_data.red_sum = red_add[SUM_W] ? '1 : red_add[SUM_W-1:0];
                wr_data.green_sum = green_add[SUM_W] ? '1 : green_add[SUM_W-1:0];
                wr_data.blue_sum = blue_add[SUM_W] ? '1 : blue_add[SUM_W-1:0];
                wr_data.weight_sum = weight_add[WSUM_W] ? '1 : weight_add[WSUM_W-1:0];
                state_next = ST_IDLE;
            end
            ST_READ:
            begin
                if (rd_data.weight_sum == '0)
                begin
                    nw_next = 1'b1;
                    state_next = ST_PUSH;
                end
                else
                begin
                    sat_next[0] = {12'd0, rd_data.red_sum} >= ws_scaled;
                    sat_next[1] = {12'd0, rd_data.green_sum} >= ws_scaled;
                    sat_next[2] = {12'd0, rd_data.blue_sum} >= ws_scaled;
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_last)
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!out_full)
                begin
                    res_push = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        res.no_weight = nw_reg;
        res.out_of_range = cmd_reg.oor;
        if (nw_reg || cmd_reg.oor)
        begin
            res.red = '0;
            res.green = '0;
            res.blue = '0;
        end
        else
        begin
            res.red = sat_reg[0] ? '1 : red_q;
            res.green = sat_reg[1] ? '1 : green_q;
            res.blue = sat_reg[2] ? '1 : blue_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clear_pos_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clear_pos_reg <= clear_pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        nw_reg <= nw_next;
        sat_reg <= sat_next;
    end

    // result queue
    assign out_pop = pop && !empty;
    assign empty = (out_count_reg == 2'd0);
    assign result = out_reg[out_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_wr_reg <= 1'b0;
            out_rd_reg <= 1'b0;
            out_count_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
                out_wr_reg <= !out_wr_reg;
            if (out_pop)
                out_rd_reg <= !out_rd_reg;
            out_count_reg <= out_count_reg + {1'b0, res_push} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_reg[out_wr_reg] <= res;
        end
    end

endmodule

// ===== rtl/wpsa_checker.sv =====
// port level checks of the accumulator and their binding
module wpsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic [23:0] pixel_red,
    input logic [23:0] pixel_green,
    input logic [23:0] pixel_blue,
    input logic        no_weight,
    input logic        out_of_range
);

    // clearing sweep holds off input right after reset
    a_full_after_reset: assert property (@(posedge clk)
        rst_n && !$past(rst_n) |-> full)
        else $error("input not held off after reset");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(no_weight && out_of_range))
        else $error("both flags set");

    a_flag_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (no_weight || out_of_range) |->
            pixel_red == 24'd0 && pixel_green == 24'd0 && pixel_blue == 24'd0)
        else $error("flagged word carries color");

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(pixel_red) && $stable(pixel_blue))
        else $error("waiting word changed");

endmodule

bind weighted_pixel_sample_accumulator_top wpsa_checker u_checker (
    .clk(clk),
    .rst_n(rst_n),
    .full(full),
    .pop(pop),
    .empty(empty),
    .pixel_red(pixel_red),
    .pixel_green(pixel_green),
    .pixel_blue(pixel_blue),
    .no_weight(no_weight),
    .out_of_range(out_of_range)
);
